/* sv/assert_macros.svh */
// assertion macros shared by the exposure sequencer rtl
// expects clk and rst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define EXS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("exposure sequencer assertion failed");

// expression must never be true out of reset
`define EXS_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("exposure sequencer forbidden condition seen");

`else

`define EXS_ASSERT(lbl, prop)
`define EXS_NEVER(lbl, expr)

`endif

`endif

/* sv/exs_pkg.sv */
// types and constants of the ccd exposure sequencer
// no dependencies; imported by every module of the block
package exs_pkg;

  // widths fixed by the item and register fields
  localparam int EXP_W   = 32;
  localparam int MHZ_W   = 10;
  localparam int PROD_W  = EXP_W + MHZ_W;
  localparam int FCNT_W  = 8;
  localparam int KIND_W  = 3;
  localparam int TIMER_W = 64;
  localparam int NRES    = 3;
  localparam int RCNT_W  = 2;

  localparam logic [MHZ_W-1:0] MHZ_RESET = MHZ_W'(100);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_EXPOSING = 2'd1,
    PH_READING  = 2'd2,
    PH_TRANSMIT = 2'd3
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_START = 3'd0,
    KIND_STOP  = 3'd1,
    KIND_ABORT = 3'd2,
    KIND_SEND  = 3'd3,
    KIND_TICK  = 3'd4,
    KIND_INTR  = 3'd5
  } kind_t;

  // one result item
  typedef struct packed {
    phase_t phase;
    logic   notify;
    logic   exposure;
    logic   send;
    logic   busy;
    logic   last;
  } res_t;

  // all results of one item, cnt in 1..NRES
  typedef struct packed {
    res_t [NRES-1:0]   res;
    logic [RCNT_W-1:0] cnt;
  } batch_t;

  // timer commands from the sequencer
  typedef struct packed {
    logic             load;
    logic             stop;
    logic             tick;
    logic [EXP_W-1:0] load_us;
  } tmr_cmd_t;

  // timer status towards the sequencer
  typedef struct packed {
    logic on;
    logic wrap;
  } tmr_sts_t;

endpackage

/* sv/exs_timer.sv */
// exposure timer: clock rate register, count load multiplier, down-counter
// depends on exs_pkg
module exs_timer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [exs_pkg::MHZ_W-1:0] cfg_wr_data,
  input  exs_pkg::tmr_cmd_t         cmd,
  output exs_pkg::tmr_sts_t         sts
);
  import exs_pkg::*;

  logic [MHZ_W-1:0]   mhz_r;
  logic [TIMER_W-1:0] tmr_r;
  logic [TIMER_W-1:0] tmr_nxt;
  logic               on_r;
  logic               on_nxt;
  logic [PROD_W-1:0]  prod;

  // ticks still to go; a count of zero means a full wrap of the counter
  assign prod     = PROD_W'(cmd.load_us) * PROD_W'(mhz_r);
  assign sts.on   = on_r;
  assign sts.wrap = on_r && (tmr_r == TIMER_W'(1));

  // stop beats load beats tick
  always_comb begin
    tmr_nxt = tmr_r;
    on_nxt  = on_r;
    priority if (cmd.stop) begin
      on_nxt = 1'b0;
    end else if (cmd.load) begin
      tmr_nxt = TIMER_W'(prod);
      on_nxt  = 1'b1;
    end else if (cmd.tick && on_r) begin
      tmr_nxt = tmr_r - TIMER_W'(1);
      on_nxt  = !sts.wrap;
    end
  end

  // control and configuration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r  <= 1'b0;
      mhz_r <= MHZ_RESET;
    end else begin
      on_r <= on_nxt;
      if (cfg_wr_en) begin
        mhz_r <= cfg_wr_data;
      end
    end
  end

  // counter value
  always_ff @(posedge clk) begin
    tmr_r <= tmr_nxt;
  end

endmodule

/* sv/exs_res_buf.sv */
// result buffer: holds the results of one item and hands them out in order
// depends on exs_pkg
`include "assert_macros.svh"
module exs_res_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  exs_pkg::batch_t batch,
  output logic            can_take,
  output logic            out_valid,
  input  logic            out_ready,
  output exs_pkg::res_t   head
);
  import exs_pkg::*;

  res_t [NRES-1:0]   ent_r;
  logic [RCNT_W-1:0] cnt_r;
  logic              pop;

  assign pop       = (cnt_r != '0) && out_ready;
  assign can_take  = (cnt_r == '0) || ((cnt_r == RCNT_W'(1)) && out_ready);
  assign out_valid = (cnt_r != '0);
  assign head      = ent_r[0];

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= batch.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - RCNT_W'(1);
    end
  end

  // entries shift towards the head as results leave
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= batch.res;
    end else if (pop) begin
      ent_r[0] <= ent_r[1];
      ent_r[1] <= ent_r[2];
    end
  end

  `EXS_NEVER(a_load_overrun, load && !can_take)
  `EXS_NEVER(a_cnt_range, cnt_r > RCNT_W'(NRES))
  `EXS_ASSERT(a_head_last, (cnt_r == RCNT_W'(1)) |-> ent_r[0].last)
  `EXS_ASSERT(a_head_not_last, (cnt_r > RCNT_W'(1)) |-> !ent_r[0].last)

endmodule

/* sv/ccd_exposure_sequencer_core.sv */
// top level of the ccd exposure sequencer: input register and phase logic
// depends on exs_pkg, exs_timer and exs_res_buf
`include "assert_macros.svh"

// Takes one item per clock unless held by the result buffer: start, stop,
// abort, send trigger, timer tick or controller interrupt, and answers each
// with one to three result items. An item passes the input register, is
// decoded in the next cycle and its results land in the result buffer, from
// which they are offered in order. Items with one result stream at one per
// cycle while out_ready stays high; a tx-done
// interrupt yields two results (three with a live-mode exception) and holds
// the input until the buffer is down to its last result and that is taken,
// since the buffer hands out one result a cycle. The exposure count is the exposure time times clock_mhz,
// taken modulo 2^64; a count of zero runs the full 2^64 ticks. clock_mhz
// resets to 100 and may be written only while no item is in flight.
module ccd_exposure_sequencer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [exs_pkg::MHZ_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [exs_pkg::KIND_W-1:0] in_kind,
  input  logic                       in_live_request,
  input  logic [exs_pkg::EXP_W-1:0]  in_exposure_time,
  input  logic                       in_tx_done_flag,
  input  logic                       in_exception_flag,
  input  logic                       in_ddr_ready,
  input  logic [exs_pkg::FCNT_W-1:0] in_frame_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_phase_out,
  output logic                       out_notify,
  output logic                       out_exposure_out,
  output logic                       out_send_pulse,
  output logic                       out_busy_status,
  output logic                       out_last_result
);
  import exs_pkg::*;

  function automatic res_t mk_res(phase_t ph, logic ntf, logic line, logic snd,
                                  logic bsy, logic lst);
    res_t r;
    r.phase    = ph;
    r.notify   = ntf;
    r.exposure = line;
    r.send     = snd;
    r.busy     = bsy;
    r.last     = lst;
    return r;
  endfunction

  // input register
  logic              s1_vld_r;
  logic [KIND_W-1:0] s1_kind_r;
  logic              s1_live_r;
  logic [EXP_W-1:0]  s1_exp_r;
  logic              s1_tx_r;
  logic              s1_exc_r;
  logic              s1_ddr_r;
  logic [FCNT_W-1:0] s1_fcnt_r;

  // sequencer state
  phase_t           phase_r, phase_nxt;
  logic             live_r, live_nxt;
  logic             line_r, line_nxt;
  logic [EXP_W-1:0] counts_r, counts_nxt;

  logic     s1_go;
  logic     can_take;
  logic     can_send;
  tmr_cmd_t cmd_raw;
  tmr_cmd_t cmd;
  tmr_sts_t tsts;
  batch_t   batch;
  res_t     head;

  assign s1_go    = s1_vld_r && can_take;
  assign in_ready = !s1_vld_r || s1_go;
  assign can_send = s1_ddr_r && (s1_fcnt_r != '0);

  // input register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_kind;
      s1_live_r <= in_live_request;
      s1_exp_r  <= in_exposure_time;
      s1_tx_r   <= in_tx_done_flag;
      s1_exc_r  <= in_exception_flag;
      s1_ddr_r  <= in_ddr_ready;
      s1_fcnt_r <= in_frame_count;
    end
  end

  // phase logic and result generation for the registered item
  always_comb begin
    phase_nxt   = phase_r;
    live_nxt    = live_r;
    line_nxt    = line_r;
    counts_nxt  = counts_r;
    cmd_raw     = '0;
    batch.res   = '0;
    batch.cnt   = RCNT_W'(1);
    batch.res[0] = mk_res(phase_r, 1'b0, line_r, 1'b0, 1'b0, 1'b1);
    unique case (s1_kind_r)
      KIND_START: begin
        if (phase_r != PH_IDLE) begin
          batch.res[0] = mk_res(phase_r, 1'b0, line_r, 1'b0, 1'b1, 1'b1);
        end else begin
          live_nxt        = s1_live_r;
          counts_nxt      = s1_exp_r;
          line_nxt        = 1'b1;
          phase_nxt       = PH_EXPOSING;
          cmd_raw.load    = 1'b1;
          cmd_raw.load_us = s1_exp_r;
          batch.res[0] = mk_res(PH_EXPOSING, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        end
      end
      KIND_STOP: begin
        line_nxt     = 1'b0;
        phase_nxt    = PH_IDLE;
        cmd_raw.stop = 1'b1;
        batch.res[0] = mk_res(PH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      KIND_ABORT: begin
        line_nxt     = 1'b0;
        cmd_raw.stop = 1'b1;
        batch.res[0] = mk_res(phase_r, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      KIND_SEND: begin
        batch.res[0] = mk_res(phase_r, 1'b0, line_r, can_send, 1'b0, 1'b1);
      end
      KIND_TICK: begin
        cmd_raw.tick = 1'b1;
        if (tsts.wrap) begin
          line_nxt     = 1'b0;
          phase_nxt    = PH_READING;
          batch.res[0] = mk_res(PH_READING, 1'b1, 1'b0, live_r && can_send,
                                1'b0, 1'b1);
        end
      end
      KIND_INTR: begin
        // tx done: transmit, then idle or a fresh exposure in live mode
        if (s1_tx_r) begin
          batch.res[0] = mk_res(PH_TRANSMIT, 1'b1, line_r, 1'b0, 1'b0, 1'b0);
          if (live_r) begin
            line_nxt        = 1'b1;
            phase_nxt       = PH_EXPOSING;
            cmd_raw.load    = 1'b1;
            cmd_raw.load_us = counts_r;
            batch.res[1] = mk_res(PH_EXPOSING, 1'b1, 1'b1, 1'b0, 1'b0,
                                  !s1_exc_r);
          end else begin
            phase_nxt    = PH_IDLE;
            batch.res[1] = mk_res(PH_IDLE, 1'b1, line_r, 1'b0, 1'b0, 1'b1);
          end
          batch.cnt = RCNT_W'(2);
        end
        // exception ends a live capture
        if (s1_exc_r && live_r) begin
          line_nxt     = 1'b0;
          phase_nxt    = PH_IDLE;
          cmd_raw.stop = 1'b1;
          if (s1_tx_r) begin
            batch.res[2] = mk_res(PH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
            batch.cnt    = RCNT_W'(3);
          end else begin
            batch.res[0] = mk_res(PH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
          end
        end
      end
      default: begin
        batch.res[0] = mk_res(phase_r, 1'b0, line_r, 1'b0, 1'b0, 1'b1);
      end
    endcase
  end

  // timer acts only for an item that is taken this cycle
  always_comb begin
    cmd      = cmd_raw;
    cmd.load = cmd_raw.load && s1_go;
    cmd.stop = cmd_raw.stop && s1_go;
    cmd.tick = cmd_raw.tick && s1_go;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      live_r  <= 1'b0;
      line_r  <= 1'b0;
    end else if (s1_go) begin
      phase_r <= phase_nxt;
      live_r  <= live_nxt;
      line_r  <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      counts_r <= counts_nxt;
    end
  end

  exs_timer u_timer (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (tsts)
  );

  exs_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_go),
    .batch     (batch),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // result ports
  assign out_phase_out    = head.phase;
  assign out_notify       = head.notify;
  assign out_exposure_out = head.exposure;
  assign out_send_pulse   = head.send;
  assign out_busy_status  = head.busy;
  assign out_last_result  = head.last;

  `EXS_ASSERT(a_line_not_reading, line_r |-> (phase_r != PH_READING && phase_r != PH_TRANSMIT))
  `EXS_ASSERT(a_line_follows_timer, line_r == tsts.on)
  `EXS_ASSERT(a_wrap_ends_exposure, (s1_go && cmd.tick && tsts.wrap) |=> !line_r)

endmodule

/* dv/testbench.sv */
// self-checking testbench for ccd_exposure_sequencer_core
// depends on exs_pkg and the core rtl; predicts every result item in step with the block
`timescale 1ns / 100ps

module testbench;
  import exs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
  localparam int IDLE_PCT = 27;
  localparam int PHASE_QUOTA = 20;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              live;
    logic [EXP_W-1:0]  exp_us;
    logic              tx_done;
    logic              exc;
    logic              ddr;
    logic [FCNT_W-1:0] frames;
  } seq_item_t;

  typedef struct packed {
    phase_t phase;
    logic   notify;
    logic   exposure;
    logic   send;
    logic   busy;
    logic   last;
  } seq_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [MHZ_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic in_live_request = 1'b0;
  logic [EXP_W-1:0] in_exposure_time = '0;
  logic in_tx_done_flag = 1'b0;
  logic in_exception_flag = 1'b0;
  logic in_ddr_ready = 1'b0;
  logic [FCNT_W-1:0] in_frame_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_phase_out;
  logic out_notify;
  logic out_exposure_out;
  logic out_send_pulse;
  logic out_busy_status;
  logic out_last_result;

  ccd_exposure_sequencer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_live_request  (in_live_request),
    .in_exposure_time (in_exposure_time),
    .in_tx_done_flag  (in_tx_done_flag),
    .in_exception_flag(in_exception_flag),
    .in_ddr_ready     (in_ddr_ready),
    .in_frame_count   (in_frame_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_phase_out    (out_phase_out),
    .out_notify       (out_notify),
    .out_exposure_out (out_exposure_out),
    .out_send_pulse   (out_send_pulse),
    .out_busy_status  (out_busy_status),
    .out_last_result  (out_last_result)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // predicted copy of the sequencer state and its register
  logic [MHZ_W-1:0] clock_mhz_copy = MHZ_RESET;
  phase_t           seq_phase = PH_IDLE;
  logic             seq_live = 1'b0;
  logic [EXP_W-1:0] seq_exp_us = '0;
  logic [63:0]      seq_timer = '0;
  logic             seq_timer_on = 1'b0;
  logic             seq_line = 1'b0;
  int               step_count;

  seq_item_t   pending_items[$];
  seq_result_t expected_results[$];
  seq_item_t   offered_item;
  logic        offering;
  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic        rdy;
  logic        calm;

  // repeating windows in which neither side idles
  assign calm = (cycle_count % 1500) >= 1100;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // expected result from the current predicted state
  task automatic emit_result(input logic notify, input logic send, input logic busy);
    seq_result_t r;
    r.phase    = seq_phase;
    r.notify   = notify;
    r.exposure = seq_line;
    r.send     = send;
    r.busy     = busy;
    r.last     = 1'b0;
    expected_results.push_back(r);
    step_count++;
  endtask

  task automatic load_exposure();
    logic [63:0] counts;
    counts       = 64'(seq_exp_us) * 64'(clock_mhz_copy);
    seq_line     = 1'b1;
    seq_timer    = 64'd0 - counts;
    seq_timer_on = 1'b1;
    seq_phase    = PH_EXPOSING;
  endtask

  task automatic halt_capture();
    seq_line     = 1'b0;
    seq_timer_on = 1'b0;
  endtask

  // works out the results of one accepted item
  task automatic advance_sequencer(input seq_item_t it);
    logic        can_send;
    logic        wrapped;
    seq_result_t tail;
    can_send   = it.ddr && (it.frames != '0);
    wrapped    = 1'b0;
    step_count = 0;
    case (it.kind)
      KIND_START: begin
        if (seq_phase != PH_IDLE) begin
          emit_result(1'b0, 1'b0, 1'b1);
        end else begin
          seq_live   = it.live;
          seq_exp_us = it.exp_us;
          load_exposure();
          emit_result(1'b1, 1'b0, 1'b0);
        end
      end
      KIND_STOP: begin
        halt_capture();
        seq_phase = PH_IDLE;
        emit_result(1'b1, 1'b0, 1'b0);
      end
      KIND_ABORT: begin
        halt_capture();
        emit_result(1'b0, 1'b0, 1'b0);
      end
      KIND_SEND: emit_result(1'b0, can_send, 1'b0);
      KIND_TICK: begin
        if (seq_timer_on) begin
          seq_timer = seq_timer + 64'd1;
          if (seq_timer == 64'd0) begin
            wrapped = 1'b1;
            seq_timer_on = 1'b0;
            seq_line = 1'b0;
            seq_phase = PH_READING;
            emit_result(1'b1, seq_live && can_send, 1'b0);
          end
        end
        if (!wrapped) emit_result(1'b0, 1'b0, 1'b0);
      end
      KIND_INTR: begin
        if (it.tx_done) begin
          seq_phase = PH_TRANSMIT;
          emit_result(1'b1, 1'b0, 1'b0);
          if (seq_live) load_exposure();
          else seq_phase = PH_IDLE;
          emit_result(1'b1, 1'b0, 1'b0);
        end
        // an exception only ends a live capture
        if (it.exc && seq_live) begin
          halt_capture();
          seq_phase = PH_IDLE;
          emit_result(1'b1, 1'b0, 1'b0);
        end
        if (step_count == 0) emit_result(1'b0, 1'b0, 1'b0);
      end
      default: emit_result(1'b0, 1'b0, 1'b0);
    endcase
    tail = expected_results.pop_back();
    tail.last = 1'b1;
    expected_results.push_back(tail);
  endtask

  // driver: offers queued items, with random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        advance_sequencer(offered_item);
        offering = 1'b0;
      end
      if (!offering && pending_items.size() > 0 &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        offered_item = pending_items.pop_front();
        in_kind           <= offered_item.kind;
        in_live_request   <= offered_item.live;
        in_exposure_time  <= offered_item.exp_us;
        in_tx_done_flag   <= offered_item.tx_done;
        in_exception_flag <= offered_item.exc;
        in_ddr_ready      <= offered_item.ddr;
        in_frame_count    <= offered_item.frames;
        offering = 1'b1;
      end
      in_valid <= offering;
    end
  end

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // monitor: checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    seq_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual phase %0d notify %0d last %0d",
                   $time, out_phase_out, out_notify, out_last_result);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("phase_out", want.phase, out_phase_out);
          check_field("notify", want.notify, out_notify);
          check_field("exposure_out", want.exposure, out_exposure_out);
          check_field("send_pulse", want.send, out_send_pulse);
          check_field("busy_status", want.busy, out_busy_status);
          check_field("last_result", want.last, out_last_result);
        end
      end
      // one long hold-off while the sender is offering, to back the block up
      if (!hold_done && in_valid && results_seen >= 100) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = calm || ($urandom_range(99) >= IDLE_PCT);
      end
      out_ready <= rdy;
    end
  end

  // stimulus helpers
  function automatic seq_item_t make_item(input logic [KIND_W-1:0] kind, input logic live,
                                          input logic [EXP_W-1:0] exp_us, input logic tx,
                                          input logic exc, input logic ddr,
                                          input logic [FCNT_W-1:0] frames);
    seq_item_t it;
    it.kind    = kind;
    it.live    = live;
    it.exp_us  = exp_us;
    it.tx_done = tx;
    it.exc     = exc;
    it.ddr     = ddr;
    it.frames  = frames;
    return it;
  endfunction

  function automatic seq_item_t rand_item(input logic [KIND_W-1:0] kind);
    logic [FCNT_W-1:0] frames;
    frames = ($urandom_range(3) == 0) ? '0 : FCNT_W'($urandom_range(255));
    return make_item(kind, 1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), frames);
  endfunction

  task automatic add_item(input seq_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_kind(input logic [KIND_W-1:0] kind);
    add_item(rand_item(kind));
  endtask

  task automatic add_ticks(input longint n);
    for (longint i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) add_kind(KIND_SEND);
      add_kind(KIND_TICK);
    end
  endtask

  task automatic add_intr(input logic tx, input logic exc);
    seq_item_t it;
    it = rand_item(KIND_INTR);
    it.tx_done = tx;
    it.exc = exc;
    add_item(it);
  endtask

  // mostly full exposure cycles with random content, some noise and broken runs
  task automatic run_random(input int quota);
    int unsigned first;
    int unsigned mhz;
    logic        live;
    logic [EXP_W-1:0] exp_us;
    longint      needed;
    seq_item_t   it;
    first = items_queued;
    mhz = clock_mhz_copy;
    while (items_queued - first < quota) begin
      if ($urandom_range(99) < 75) begin
        live = 1'($urandom_range(1));
        if (mhz <= 3) exp_us = $urandom_range(4, 1);
        else exp_us = ($urandom_range(2) == 0) ? 1 : $urandom;
        needed = longint'(exp_us) * longint'(mhz);
        it = rand_item(KIND_START);
        it.live = live;
        it.exp_us = exp_us;
        add_item(it);
        if (needed <= 24) begin
          add_ticks(needed);
          if ($urandom_range(4) == 0) add_kind(KIND_TICK);
          add_intr(1'b1, $urandom_range(3) == 0);
          if (live) begin
            add_ticks(needed);
            add_intr(1'($urandom_range(1)), 1'b1);
          end
        end else begin
          add_ticks($urandom_range(5, 1));
          if ($urandom_range(1)) add_kind(KIND_START);
          add_kind($urandom_range(1) ? KIND_ABORT : KIND_SEND);
          add_kind(KIND_STOP);
        end
      end else begin
        repeat ($urandom_range(3, 1)) add_item(rand_item(KIND_W'($urandom_range(7))));
        add_kind(KIND_STOP);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_clock_mhz(input logic [MHZ_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    clock_mhz_copy = value;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // run control
  initial begin
    int unsigned mhz_plan[4] = '{1000, 23, 2, 3};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: register at reset value, zero and largest counts, busy start
    add_item(make_item(KIND_START, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0));
    add_item(make_item(KIND_TICK, 1'b1, '1, 1'b1, 1'b1, 1'b1, 8'd255));
    add_item(make_item(KIND_ABORT, 1'b1, '1, 1'b1, 1'b1, 1'b1, 8'd255));
    add_item(make_item(KIND_TICK, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 8'd1));
    add_item(make_item(KIND_STOP, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0));
    add_item(make_item(KIND_STOP, 1'b1, '1, 1'b1, 1'b1, 1'b1, 8'd255));
    add_item(make_item(KIND_START, 1'b1, '1, 1'b0, 1'b0, 1'b1, 8'd255));
    add_item(make_item(KIND_START, 1'b0, 32'd5, 1'b0, 1'b0, 1'b0, 8'd0));
    add_item(make_item(KIND_SEND, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 8'd255));
    add_item(make_item(KIND_SEND, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 8'd0));
    add_item(make_item(KIND_SEND, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 8'd255));
    add_item(make_item(KIND_INTR, 1'b0, 32'd0, 1'b0, 1'b1, 1'b0, 8'd0));
    add_item(make_item(KIND_SPARE6, 1'b1, '1, 1'b1, 1'b1, 1'b1, 8'd255));
    add_item(make_item(KIND_SPARE7, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0));
    add_item(make_item(KIND_INTR, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 8'd3));
    wait_drained();

    // directed: short counts that wrap, single and live frames
    write_clock_mhz(MHZ_W'(1));
    add_item(make_item(KIND_START, 1'b0, 32'd2, 1'b0, 1'b0, 1'b1, 8'd1));
    add_item(make_item(KIND_TICK, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 8'd1));
    add_item(make_item(KIND_TICK, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 8'd1));
    add_item(make_item(KIND_INTR, 1'b0, 32'd0, 1'b1, 1'b1, 1'b0, 8'd0));
    add_item(make_item(KIND_START, 1'b1, 32'd1, 1'b0, 1'b0, 1'b0, 8'd0));
    add_item(make_item(KIND_TICK, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 8'd5));
    add_item(make_item(KIND_INTR, 1'b0, 32'd0, 1'b1, 1'b1, 1'b0, 8'd0));
    add_item(make_item(KIND_INTR, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0, 8'd0));
    add_item(make_item(KIND_STOP, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0));
    run_random(PHASE_QUOTA);
    wait_drained();

    // random runs over further register settings
    foreach (mhz_plan[i]) begin
      write_clock_mhz(MHZ_W'(mhz_plan[i]));
      run_random(PHASE_QUOTA);
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
